// ===== design/ppi_pkg.sv =====
// shared types and constants of the positional / incremental pid controller
// no dependencies

package ppi_pkg;

  localparam int DATA_W        = 32;
  localparam int OP_W          = 34;
  localparam int LIMIT_W       = 31;
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int INTEG_LIMIT_UNITS = 5;

  typedef enum logic {
    MODE_POS = 1'b0,
    MODE_INC = 1'b1
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE        = 3'd0,
    CFG_GAIN_P      = 3'd1,
    CFG_GAIN_I      = 3'd2,
    CFG_GAIN_D      = 3'd3,
    CFG_OUT_UPPER   = 3'd4,
    CFG_OUT_LOWER   = 3'd5,
    CFG_INTEG_LIMIT = 3'd6
  } cfg_idx_t;

endpackage

// ===== design/pid_position_incremental.sv =====
// positional / incremental pid controller, four register stages
// (input, operand, product, output); depends on ppi_pkg
// throughput: one sample per cycle; only a stalled output holds back the pipeline
// reset (synchronous, rst_n low): registers to reset values, error history,
// integral and held output to zero, pipeline empty

module pid_position_incremental #(
  parameter int FRAC_BITS = ppi_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [ppi_pkg::DATA_W-1:0]  in_measured,
  input  logic signed [ppi_pkg::DATA_W-1:0]  in_target,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ppi_pkg::DATA_W-1:0]  out_drive,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ppi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppi_pkg::DATA_W-1:0]         cfg_data
);

  localparam int DW = ppi_pkg::DATA_W;
  localparam int OW = ppi_pkg::OP_W;
  localparam int LW = ppi_pkg::LIMIT_W;
  localparam int PW = OW + DW;
  localparam int SW = PW - FRAC_BITS;
  localparam int AW = SW + 2;
  localparam logic [LW-1:0] INTEG_RST =
    LW'(ppi_pkg::INTEG_LIMIT_UNITS * (1 << FRAC_BITS));

  // configuration
  ppi_pkg::mode_t         cfg_mode_r;
  logic signed [DW-1:0]   cfg_gain_p_r, cfg_gain_i_r, cfg_gain_d_r;
  logic signed [DW-1:0]   cfg_out_upper_r, cfg_out_lower_r;
  logic [LW-1:0]          cfg_integ_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r        <= ppi_pkg::MODE_POS;
      cfg_gain_p_r      <= '0;
      cfg_gain_i_r      <= '0;
      cfg_gain_d_r      <= '0;
      cfg_out_upper_r   <= DW'(32'sh7FFF_FFFF);
      cfg_out_lower_r   <= DW'(32'sh8000_0000);
      cfg_integ_limit_r <= INTEG_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ppi_pkg::CFG_MODE:        cfg_mode_r        <= ppi_pkg::mode_t'(cfg_data[0]);
        ppi_pkg::CFG_GAIN_P:      cfg_gain_p_r      <= $signed(cfg_data);
        ppi_pkg::CFG_GAIN_I:      cfg_gain_i_r      <= $signed(cfg_data);
        ppi_pkg::CFG_GAIN_D:      cfg_gain_d_r      <= $signed(cfg_data);
        ppi_pkg::CFG_OUT_UPPER:   cfg_out_upper_r   <= $signed(cfg_data);
        ppi_pkg::CFG_OUT_LOWER:   cfg_out_lower_r   <= $signed(cfg_data);
        ppi_pkg::CFG_INTEG_LIMIT: cfg_integ_limit_r <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic a_valid_r, b_valid_r, c_valid_r, out_valid_r;
  logic a_free, b_free, c_free, d_free;
  logic a_load, b_load, c_load, d_load;

  assign d_free   = !out_valid_r || out_ready;
  assign c_free   = !c_valid_r || d_free;
  assign b_free   = !b_valid_r || c_free;
  assign a_free   = !a_valid_r || b_free;
  assign in_ready = a_free;
  assign a_load   = a_free && in_valid;
  assign b_load   = b_free && a_valid_r;
  assign c_load   = c_free && b_valid_r;
  assign d_load   = d_free && c_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_free) a_valid_r   <= in_valid;
      if (b_free) b_valid_r   <= a_valid_r;
      if (c_free) c_valid_r   <= b_valid_r;
      if (d_free) out_valid_r <= c_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  // input stage
  logic signed [DW-1:0] a_measured_r, a_target_r;

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_measured_r <= in_measured;
      a_target_r   <= in_target;
    end
  end

  // operand stage: error, history and integral
  logic signed [DW-1:0] err_now_r, err_prev_r, err_prev2_r, err_sum_r;
  logic signed [DW:0]   diff, sum_s, lim_s, sum_c;
  logic signed [DW-1:0] err;
  logic signed [OW-1:0] e_x, en_x, ep_x;
  logic signed [OW-1:0] op_p_nxt, op_i_nxt, op_d_nxt;
  logic signed [OW-1:0] b_op_p_r, b_op_i_r, b_op_d_r;

  always_comb begin
    diff = (DW+1)'(a_target_r) - (DW+1)'(a_measured_r);
    if (diff[DW] != diff[DW-1]) begin
      err = diff[DW] ? DW'(32'sh8000_0000) : DW'(32'sh7FFF_FFFF);
    end else begin
      err = diff[DW-1:0];
    end
    sum_s = (DW+1)'(err_sum_r) + (DW+1)'(err);
    lim_s = $signed({2'b00, cfg_integ_limit_r});
    if (sum_s > lim_s) begin
      sum_c = lim_s;
    end else if (sum_s < -lim_s) begin
      sum_c = -lim_s;
    end else begin
      sum_c = sum_s;
    end
    e_x  = OW'(err);
    en_x = OW'(err_now_r);
    ep_x = OW'(err_prev_r);
    if (cfg_mode_r == ppi_pkg::MODE_INC) begin
      op_p_nxt = e_x - en_x;
      op_i_nxt = e_x;
      op_d_nxt = e_x - (en_x <<< 1) + ep_x;
    end else begin
      op_p_nxt = e_x;
      op_i_nxt = OW'(sum_c);
      op_d_nxt = e_x - en_x;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_now_r   <= '0;
      err_prev_r  <= '0;
      err_prev2_r <= '0;
      err_sum_r   <= '0;
    end else if (b_load) begin
      err_now_r  <= err;
      err_prev_r <= err_now_r;
      if (cfg_mode_r == ppi_pkg::MODE_INC) begin
        err_prev2_r <= err_prev_r;
      end else begin
        err_sum_r <= sum_c[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_op_p_r <= op_p_nxt;
      b_op_i_r <= op_i_nxt;
      b_op_d_r <= op_d_nxt;
    end
  end

  // product stage, floor shift of exact products
  logic signed [PW-1:0] prod_p, prod_i, prod_d;
  logic signed [SW-1:0] c_p_r, c_i_r, c_d_r;

  assign prod_p = PW'(b_op_p_r) * PW'(cfg_gain_p_r);
  assign prod_i = PW'(b_op_i_r) * PW'(cfg_gain_i_r);
  assign prod_d = PW'(b_op_d_r) * PW'(cfg_gain_d_r);

  always_ff @(posedge clk) begin
    if (c_load) begin
      c_p_r <= SW'(prod_p >>> FRAC_BITS);
      c_i_r <= SW'(prod_i >>> FRAC_BITS);
      c_d_r <= SW'(prod_d >>> FRAC_BITS);
    end
  end

  // output stage: sum, clamp, held output
  logic signed [DW-1:0] held_out_r, drive_nxt;
  logic signed [AW-1:0] held_term, acc;

  always_comb begin
    held_term = (cfg_mode_r == ppi_pkg::MODE_INC) ? AW'(held_out_r) : '0;
    acc = AW'(c_p_r) + AW'(c_i_r) + AW'(c_d_r) + held_term;
    if (acc > AW'(cfg_out_upper_r)) begin
      drive_nxt = cfg_out_upper_r;
    end else if (acc < AW'(cfg_out_lower_r)) begin
      drive_nxt = cfg_out_lower_r;
    end else begin
      drive_nxt = acc[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_out_r <= '0;
    end else if (d_load) begin
      held_out_r <= drive_nxt;
    end
  end

  assign out_drive = held_out_r;

`ifndef SYNTHESIS
  a_no_stall_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with an empty output register");

  a_drive_limits : assert property (@(posedge clk) disable iff (!rst_n)
    d_load |=> (held_out_r <= $past(cfg_out_upper_r)) ||
               (held_out_r == $past(cfg_out_lower_r)))
    else $error("drive outside output limits");

  a_integ_bound : assert property (@(posedge clk) disable iff (!rst_n)
    b_load && (cfg_mode_r == ppi_pkg::MODE_POS) |=>
      ((DW+1)'(err_sum_r) <= $signed({2'b00, $past(cfg_integ_limit_r)})) &&
      ((DW+1)'(err_sum_r) >= -$signed({2'b00, $past(cfg_integ_limit_r)})))
    else $error("integral outside its limit");
`endif

endmodule
